### hdl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and codes shared by the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_PAGE = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_CALC,
		S_INIT_FILL,
		S_ALLOC_SCAN,
		S_FREE_CHK
	} state_t;

	localparam logic REG_MEMORY_BYTES    = 1'b0;
	localparam logic REG_KERNEL_END_ADDR = 1'b1;

	localparam int WORD_BITS  = 32;
	localparam int COUNT_BITS = 13;

endpackage

### hdl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// latency, start to done: alloc scans to a free page or last word; init sizes, fills
// all words; valid free checks one word; ignored free or unused op ends from idle.
// throughput: one transaction at a time; the map word scan through the single
// read port of the map memory, one word per cycle, sets the alloc time.
// done is a one-cycle strobe that cannot be stalled; start is taken when busy is low.
// reset clears counts and config; the map memory is rewritten by each init.
module bitmap_page_allocator #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] free_addr,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output logic [31:0] page_addr,
	output logic [1:0]  status,
	output logic [12:0] inuse_pages,
	output logic [12:0] free_pages,
	output logic [12:0] managed_pages
);

	localparam int L         = $clog2(PAGE_BYTES);
	localparam int CW        = $clog2(MAX_PAGES + 1);
	localparam int PW        = CW - 5;
	localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
	localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int NB        = bpa_pkg::COUNT_BITS;

	bpa_pkg::state_t  state_q, state_d;
	bpa_pkg::status_t status_q;

	logic [31:0]   memory_bytes_q, kernel_end_addr_q;
	logic [CW-1:0] page_count_q, first_q, used_count_q;
	logic [PW-1:0] word_q;
	logic [4:0]    fbit_q;
	logic          done_q;
	logic [31:0]   page_addr_q;

	// map memory
	logic [31:0]   map_mem [MAP_WORDS];
	logic [31:0]   rd_data_s1;
	logic [WW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_data;
	logic          wr_en;

	// init arithmetic
	logic [32:0]   tot_w, kpg_w, bpg_w, first_w;
	logic [CW-1:0] total_c, first_c;

	// free request checks
	logic [31:0]   fpage;
	logic          free_ok;

	// window and find-first-zero unit
	logic [PW-1:0] fw, cw, last_w, w_next;
	logic [CW-1:0] cnt_m1;
	logic [31:0]   ge_mask, lt_mask, free_win, zero_bits;
	logic          found;
	logic [4:0]    ffz;
	logic          scan_last, fill_last, accept;

	logic [CW-1:0]      page_num;
	logic [CW+L+31:0]   page_wide;
	logic [CW+NB-1:0]   used_wide, free_wide, total_wide;

	assign accept = start && (state_q == bpa_pkg::S_IDLE);

	// init sizing
	assign tot_w   = {1'b0, memory_bytes_q} >> L;
	assign total_c = (tot_w > 33'(MAX_PAGES)) ? CW'(MAX_PAGES) : tot_w[CW-1:0];
	assign kpg_w   = ({1'b0, kernel_end_addr_q} + 33'(PAGE_BYTES - 1)) >> L;
	assign bpg_w   = ({{(33-CW){1'b0}}, total_c >> 3} + 33'(PAGE_BYTES - 1)) >> L;
	assign first_w = kpg_w + bpg_w;
	assign first_c = (first_w > 33'(MAX_PAGES)) ? CW'(MAX_PAGES) : first_w[CW-1:0];

	assign fpage   = free_addr >> L;
	assign free_ok = (free_addr != 32'd0) && ((free_addr & 32'(PAGE_BYTES - 1)) == 32'd0)
		&& (fpage >= 32'(first_q)) && (fpage < 32'(page_count_q));

	// free window of the current word: pages in [first, count)
	assign fw      = first_q[CW-1:5];
	assign cw      = page_count_q[CW-1:5];
	assign cnt_m1  = page_count_q - 1'b1;
	assign last_w  = cnt_m1[CW-1:5];
	assign w_next  = word_q + 1'b1;
	assign ge_mask = (word_q > fw) ? '1 : ((word_q == fw) ? ('1 << first_q[4:0]) : '0);
	assign lt_mask = (word_q < cw) ? '1 : ((word_q == cw) ? ~('1 << page_count_q[4:0]) : '0);
	assign free_win  = ge_mask & lt_mask;
	assign zero_bits = ~rd_data_s1 & free_win;
	assign found     = |zero_bits;

	always_comb begin
		ffz = '0;
		for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (zero_bits[i]) begin
				ffz = 5'(i);
			end
		end
	end

	assign scan_last = (word_q == last_w);
	assign fill_last = (word_q == PW'(MAP_WORDS - 1));
	assign page_num  = {word_q, ffz};
	assign page_wide = {32'd0, page_num, {L{1'b0}}};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (start) begin
					case (op)
						bpa_pkg::OP_ALLOC: begin
							if (first_q < page_count_q) state_d = bpa_pkg::S_ALLOC_SCAN;
						end
						bpa_pkg::OP_FREE: begin
							if (free_ok) state_d = bpa_pkg::S_FREE_CHK;
						end
						bpa_pkg::OP_INIT: state_d = bpa_pkg::S_INIT_CALC;
						default: state_d = bpa_pkg::S_IDLE;
					endcase
				end
			end
			bpa_pkg::S_INIT_CALC: state_d = bpa_pkg::S_INIT_FILL;
			bpa_pkg::S_INIT_FILL: begin
				if (fill_last) state_d = bpa_pkg::S_IDLE;
			end
			bpa_pkg::S_ALLOC_SCAN: begin
				if (found || scan_last) state_d = bpa_pkg::S_IDLE;
			end
			bpa_pkg::S_FREE_CHK: state_d = bpa_pkg::S_IDLE;
			default: state_d = bpa_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q[WW-1:0];
		wr_data = rd_data_s1;
		rd_addr = w_next[WW-1:0];
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (op == bpa_pkg::OP_ALLOC) rd_addr = fw[WW-1:0];
				else rd_addr = fpage[WW+4:5];
			end
			bpa_pkg::S_INIT_CALC: ;
			bpa_pkg::S_INIT_FILL: begin
				wr_en   = 1'b1;
				wr_data = ~free_win;
			end
			bpa_pkg::S_ALLOC_SCAN: begin
				wr_en   = found;
				wr_data = rd_data_s1 | (32'd1 << ffz);
			end
			bpa_pkg::S_FREE_CHK: begin
				wr_en   = rd_data_s1[fbit_q];
				wr_data = rd_data_s1 & ~(32'd1 << fbit_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) map_mem[wr_addr] <= wr_data;
		rd_data_s1 <= map_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= bpa_pkg::S_IDLE;
			done_q            <= 1'b0;
			memory_bytes_q    <= '0;
			kernel_end_addr_q <= '0;
			page_count_q      <= '0;
			first_q           <= '0;
			used_count_q      <= '0;
			word_q            <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == bpa_pkg::REG_MEMORY_BYTES) memory_bytes_q <= cfg_wdata;
				else kernel_end_addr_q <= cfg_wdata;
			end
			unique case (state_q)
				bpa_pkg::S_IDLE: begin
					if (accept) begin
						word_q <= (op == bpa_pkg::OP_ALLOC) ? fw : fpage[PW+4:5];
						if (state_d == bpa_pkg::S_IDLE) done_q <= 1'b1;
					end
				end
				bpa_pkg::S_INIT_CALC: begin
					page_count_q <= total_c;
					first_q      <= first_c;
					used_count_q <= (first_c < total_c) ? first_c : total_c;
					word_q       <= '0;
				end
				bpa_pkg::S_INIT_FILL: begin
					word_q <= w_next;
					if (fill_last) done_q <= 1'b1;
				end
				bpa_pkg::S_ALLOC_SCAN: begin
					if (found) begin
						used_count_q <= used_count_q + 1'b1;
						done_q       <= 1'b1;
					end else begin
						word_q <= w_next;
						if (scan_last) done_q <= 1'b1;
					end
				end
				bpa_pkg::S_FREE_CHK: begin
					if (rd_data_s1[fbit_q]) used_count_q <= used_count_q - 1'b1;
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (accept) begin
					fbit_q      <= fpage[4:0];
					page_addr_q <= '0;
					case (op)
						bpa_pkg::OP_ALLOC: status_q <= bpa_pkg::ST_NO_PAGE;
						bpa_pkg::OP_FREE:  status_q <= bpa_pkg::ST_IGNORED;
						default:           status_q <= bpa_pkg::ST_DONE;
					endcase
				end
			end
			bpa_pkg::S_INIT_CALC: ;
			bpa_pkg::S_INIT_FILL: ;
			bpa_pkg::S_ALLOC_SCAN: begin
				if (found) begin
					page_addr_q <= page_wide[31:0];
					status_q    <= bpa_pkg::ST_DONE;
				end
			end
			bpa_pkg::S_FREE_CHK: begin
				if (rd_data_s1[fbit_q]) status_q <= bpa_pkg::ST_DONE;
			end
			default: ;
		endcase
	end

	assign used_wide  = {{NB{1'b0}}, used_count_q};
	assign free_wide  = {{NB{1'b0}}, page_count_q - used_count_q};
	assign total_wide = {{NB{1'b0}}, page_count_q};

	assign busy          = (state_q != bpa_pkg::S_IDLE);
	assign done          = done_q;
	assign page_addr     = page_addr_q;
	assign status        = status_q;
	assign inuse_pages   = used_wide[NB-1:0];
	assign free_pages    = free_wide[NB-1:0];
	assign managed_pages = total_wide[NB-1:0];

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_used_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= page_count_q) else $error("used count above page count");

	a_first_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_q <= CW'(MAX_PAGES)) else $error("first usable page out of range");

	a_no_page_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == bpa_pkg::ST_NO_PAGE) |-> (page_addr_q == 32'd0))
		else $error("address given with no free page");

	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == bpa_pkg::OP_INIT) |=> (busy && !done))
		else $error("init transaction did not start the fill");

endmodule
